[src/sabtb_pkg.sv]
// sabtb_pkg: shared types and constants of the set-associative branch target buffer
// used by the controller, the datapath and the top level

package sabtb_pkg;

  // width of the global aging stamp kept per entry
  localparam int STAMP_BITS = 64;

  // configuration register indexes
  localparam logic [0:0] CFG_HIT_AGE_STEP = 1'd0;
  localparam logic [0:0] CFG_MISS_PENALTY = 1'd1;

  // reset values of the configuration registers
  localparam logic [7:0] HIT_AGE_STEP_RST = 8'd1;
  localparam logic [7:0] MISS_PENALTY_RST = 8'd8;

  // branch type codes that count as non-conditional
  localparam logic [2:0] BR_UNCOND  = 3'd1;
  localparam logic [2:0] BR_SYSCALL = 3'd4;

  // one way of a set as held in the set memory
  typedef struct packed {
    logic                  valid;
    logic [31:0]           tag;
    logic [31:0]           target;
    logic                  cls;
    logic [STAMP_BITS-1:0] stamp;
  } sabtb_entry_t;

  localparam int ENTRY_W = $bits(sabtb_entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic clear_en;
    logic rd_en;
    logic commit;
  } sabtb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sabtb_sts_t;

endpackage

[src/sabtb_ram.sv]
// sabtb_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies

module sabtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/sabtb_ctrl.sv]
// sabtb_ctrl: sequencer of the branch target buffer (clear pass, set lookup, write back)
// depends on sabtb_pkg for the command and status structs

module sabtb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output sabtb_pkg::sabtb_cmd_t cmd,
  input  sabtb_pkg::sabtb_sts_t sts
);

  import sabtb_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_READ,
    ST_LOOK
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_LOOK;
      ST_LOOK:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands decoded from the state
  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state_r == ST_IDLE) && in_valid;
    cmd.clear_en = (state_r == ST_CLEAR);
    cmd.rd_en    = (state_r == ST_READ);
    cmd.commit   = (state_r == ST_LOOK) && sts.out_free;
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

[src/sabtb_dp.sv]
// sabtb_dp: datapath of the branch target buffer: set index, set memory, hit and
// victim selection, aging by global stamp, counters and result register; uses sabtb_pkg

module sabtb_dp #(
  parameter int ENTRY_COUNT = 1024,
  parameter int WAY_COUNT   = 4,
  parameter int AGE_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic [31:0]           in_branch_address,
  input  logic [3:0]            in_branch_length,
  input  logic [2:0]            in_branch_type,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [7:0]            out_set_index,
  output logic [1:0]            out_way_index,
  output logic                  out_evicted,
  output logic [7:0]            out_stall_cycles,
  output logic [31:0]           out_hit_total,
  output logic [31:0]           out_miss_total,
  input  sabtb_pkg::sabtb_cmd_t cmd,
  output sabtb_pkg::sabtb_sts_t sts
);

  import sabtb_pkg::*;

  localparam int SET_COUNT = ENTRY_COUNT / WAY_COUNT;
  localparam int SET_BITS  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_BITS  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int ROW_W     = WAY_COUNT * ENTRY_W;
  // reciprocal of the set count, scaled by 2^32
  localparam logic [32:0] RECIP_V = 33'((64'd1 << 32) / SET_COUNT);
  localparam logic [29:0] DIV_V   = 30'(SET_COUNT);
  localparam logic [SET_BITS-1:0] CLR_LAST_V = SET_BITS'(SET_COUNT - 1);

  // configuration
  logic [7:0] hit_step_r;
  logic [7:0] miss_pen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_step_r <= HIT_AGE_STEP_RST;
      miss_pen_r <= MISS_PENALTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIT_AGE_STEP: hit_step_r <= cfg_data;
        CFG_MISS_PENALTY: miss_pen_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input item capture
  logic [31:0] addr_r;
  logic [3:0]  len_r;
  logic [2:0]  type_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      addr_r <= in_branch_address;
      len_r  <= in_branch_length;
      type_r <= in_branch_type;
    end
  end

  // set index = (address >> 2) mod set count, by reciprocal multiply and one correction
  logic [62:0]         prod_r;
  logic [29:0]         qd_r;
  logic [29:0]         rem_est;
  logic [29:0]         rem_fix;
  logic [SET_BITS-1:0] set_comb;
  logic [SET_BITS-1:0] set_r;

  always_ff @(posedge clk) begin
    prod_r <= {33'd0, addr_r[31:2]} * {30'd0, RECIP_V};
    qd_r   <= prod_r[61:32] * DIV_V;
  end

  always_comb begin
    rem_est  = addr_r[31:2] - qd_r;
    rem_fix  = (rem_est >= DIV_V) ? (rem_est - DIV_V) : rem_est;
    set_comb = rem_fix[SET_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      set_r <= set_comb;
    end
  end

  // clear pass over the set memory after reset
  logic [SET_BITS-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt_r <= clr_cnt_r + SET_BITS'(1);
    end
  end

  assign sts.clear_last = (clr_cnt_r == CLR_LAST_V);

  // set memory, one row per set
  logic [ROW_W-1:0]    row_rd;
  logic [ROW_W-1:0]    row_wr;
  logic [ROW_W-1:0]    row_new;
  logic [SET_BITS-1:0] waddr;
  logic                we;

  assign we     = cmd.clear_en | cmd.commit;
  assign waddr  = cmd.clear_en ? clr_cnt_r : set_r;
  assign row_wr = cmd.clear_en ? '0 : row_new;

  sabtb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_set_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (row_wr),
    .re    (cmd.rd_en),
    .raddr (set_comb),
    .rdata (row_rd)
  );

  // global aging stamp: an entry's age is the stamp growth since it was last written
  logic [STAMP_BITS-1:0] glob_r;
  logic [STAMP_BITS-1:0] glob_nxt;
  logic [31:0]           hit_cnt_r;
  logic [31:0]           miss_cnt_r;

  // lookup, replacement choice and updated row
  sabtb_entry_t          ways [WAY_COUNT];
  logic [AGE_BITS-1:0]   age [WAY_COUNT];
  logic                  hit_any;
  logic [WAY_BITS-1:0]   hit_way;
  logic                  inv_any;
  logic [WAY_BITS-1:0]   inv_way;
  logic [WAY_BITS-1:0]   vic_way;
  logic [WAY_BITS-1:0]   inst_way;
  logic                  cls_bit;
  sabtb_entry_t          new_ent;

  always_comb begin
    logic [STAMP_BITS-1:0] diff;
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    vic_way = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      ways[w] = row_rd[w*ENTRY_W +: ENTRY_W];
    end

    // hit search, lowest matching way
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!hit_any && ways[w].valid && (ways[w].tag == addr_r)) begin
        hit_any = 1'b1;
        hit_way = WAY_BITS'(w);
      end
    end

    glob_nxt = glob_r + STAMP_BITS'(hit_any ? hit_step_r : miss_pen_r);

    // saturated age of every way after this branch's aging
    for (int w = 0; w < WAY_COUNT; w++) begin
      diff   = glob_nxt - ways[w].stamp;
      age[w] = (|diff[STAMP_BITS-1:AGE_BITS]) ? '1 : diff[AGE_BITS-1:0];
    end

    // lowest invalid way
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!inv_any && !ways[w].valid) begin
        inv_any = 1'b1;
        inv_way = WAY_BITS'(w);
      end
    end

    // oldest way, a tie goes to the higher way
    for (int w = 1; w < WAY_COUNT; w++) begin
      if (!(age[vic_way] > age[w])) begin
        vic_way = WAY_BITS'(w);
      end
    end

    inst_way = hit_any ? hit_way : (inv_any ? inv_way : vic_way);
    cls_bit  = (type_r >= BR_UNCOND) && (type_r <= BR_SYSCALL);

    new_ent        = ways[inst_way];
    new_ent.stamp  = glob_r;
    if (!hit_any) begin
      new_ent.valid  = 1'b1;
      new_ent.tag    = addr_r;
      new_ent.target = addr_r + 32'(len_r);
      new_ent.cls    = cls_bit;
      new_ent.stamp  = glob_nxt;
    end

    row_new = row_rd;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (WAY_BITS'(w) == inst_way) begin
        row_new[w*ENTRY_W +: ENTRY_W] = new_ent;
      end
    end
  end

  // stamp and running counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glob_r     <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (cmd.commit) begin
      glob_r <= glob_nxt;
      if (hit_any) begin
        hit_cnt_r <= hit_cnt_r + 32'd1;
      end else begin
        miss_cnt_r <= miss_cnt_r + 32'd1;
      end
    end
  end

  // result register
  logic        out_valid_r;
  logic        out_hit_r;
  logic [7:0]  out_set_r;
  logic [1:0]  out_way_r;
  logic        out_evict_r;
  logic [7:0]  out_stallc_r;
  logic [31:0] out_hit_tot_r;
  logic [31:0] out_miss_tot_r;
  logic [31:0] set_ext;
  logic [31:0] way_ext;

  assign set_ext = 32'(set_r);
  assign way_ext = 32'(inst_way);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r      <= hit_any;
      out_set_r      <= set_ext[7:0];
      out_way_r      <= way_ext[1:0];
      out_evict_r    <= !hit_any && !inv_any;
      out_stallc_r   <= hit_any ? 8'd0 : miss_pen_r;
      out_hit_tot_r  <= hit_any ? (hit_cnt_r + 32'd1) : hit_cnt_r;
      out_miss_tot_r <= hit_any ? miss_cnt_r : (miss_cnt_r + 32'd1);
    end
  end

  assign sts.out_free     = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_set_index    = out_set_r;
  assign out_way_index    = out_way_r;
  assign out_evicted      = out_evict_r;
  assign out_stall_cycles = out_stallc_r;
  assign out_hit_total    = out_hit_tot_r;
  assign out_miss_total   = out_miss_tot_r;

endmodule

[src/set_assoc_btb_lru_counters_core.sv]
// Set-associative branch target buffer with saturating age replacement.
// Input channel (in_valid / in_stall): one branch per transfer (address, length, type).
// Result channel (out_valid / out_stall): one result per branch: hit, set, way,
// eviction flag, stall cycles and the running hit and miss totals.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 hit age step, 1 miss penalty); write only while the block is idle.
// From input transfer to result valid a branch passes the reciprocal multiply
// for the set index (MUL1, MUL2), the set memory read, then lookup and write back.
// Input is taken only while idle, so the next branch is accepted only after the
// read-modify-write of the set memory for the previous one has been done.
// Aging is done through one global stamp, so no per-entry sweep is needed.
// Reset: synchronous, active low. After reset a clear pass writes every set
// memory row with in_stall high; config writes are taken during that pass.
// Receiver stall: a result waits in the output register; the next branch is
// accepted and processed, and its write back holds until the register frees.
// Depends on sabtb_pkg, sabtb_ctrl, sabtb_dp and sabtb_ram.

module set_assoc_btb_lru_counters_core #(
  parameter int ENTRY_COUNT = 1024,
  parameter int WAY_COUNT   = 4,
  parameter int AGE_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_branch_address,
  input  logic [3:0]  in_branch_length,
  input  logic [2:0]  in_branch_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [7:0]  out_set_index,
  output logic [1:0]  out_way_index,
  output logic        out_evicted,
  output logic [7:0]  out_stall_cycles,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total
);

  import sabtb_pkg::*;

  sabtb_cmd_t cmd;
  sabtb_sts_t sts;

  // sequencer
  sabtb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath with set memory
  sabtb_dp #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .WAY_COUNT   (WAY_COUNT),
    .AGE_BITS    (AGE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_branch_address (in_branch_address),
    .in_branch_length  (in_branch_length),
    .in_branch_type    (in_branch_type),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_set_index     (out_set_index),
    .out_way_index     (out_way_index),
    .out_evicted       (out_evicted),
    .out_stall_cycles  (out_stall_cycles),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

[src/sabtb_chk.sv]
// sabtb_chk: port-level checks of the branch target buffer over time
// bound to set_assoc_btb_lru_counters_core; no package needed

module sabtb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic        out_evicted,
  input logic [7:0]  out_stall_cycles,
  input logic [7:0]  out_set_index,
  input logic [1:0]  out_way_index,
  input logic [31:0] out_hit_total,
  input logic [31:0] out_miss_total
);

  // a stalled result holds until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_hit) &&
      $stable(out_set_index) && $stable(out_way_index) &&
      $stable(out_hit_total) && $stable(out_miss_total)))
    else $error("stalled result changed");

  // no result right after reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the clear pass holds off input right after reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clear pass");

  // a hit neither evicts nor stalls
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (!out_evicted && (out_stall_cycles == 8'd0)))
    else $error("hit reported eviction or stall");

endmodule

bind set_assoc_btb_lru_counters_core sabtb_chk u_sabtb_chk (.*);

[dv/tb_set_assoc_btb_lru_counters_core.sv]
// tb_set_assoc_btb_lru_counters_core: self-checking bench for the set-associative btb core
// drives random and directed branches, predicts each lookup result and compares it on transfer
// depends on sabtb_pkg and set_assoc_btb_lru_counters_core

module tb_set_assoc_btb_lru_counters_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sabtb_pkg::*;

  localparam int ENTRIES     = 1024;
  localparam int WAYS        = 4;
  localparam int AGE_W       = 16;
  localparam int SETS        = ENTRIES / WAYS;
  localparam int unsigned AGE_CEIL = (1 << AGE_W) - 1;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 210;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int POOL_DEPTH   = 48;

  typedef struct {
    logic [31:0] address;
    logic [3:0]  length;
    logic [2:0]  kind;
  } branch_t;

  typedef struct {
    logic        hit;
    logic [7:0]  set_index;
    logic [1:0]  way_index;
    logic        evicted;
    logic [7:0]  stall_cycles;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } lookup_t;

  // dut ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_HIT_AGE_STEP;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_branch_address = 32'd0;
  logic [3:0]  in_branch_length = 4'd0;
  logic [2:0]  in_branch_type = 3'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_hit;
  logic [7:0]  out_set_index;
  logic [1:0]  out_way_index;
  logic        out_evicted;
  logic [7:0]  out_stall_cycles;
  logic [31:0] out_hit_total;
  logic [31:0] out_miss_total;

  // predictor copy of the buffer
  logic        btb_valid  [ENTRIES];
  logic [31:0] btb_tag    [ENTRIES];
  logic [31:0] btb_target [ENTRIES];
  logic        btb_class  [ENTRIES];
  int unsigned btb_age    [ENTRIES];
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic [7:0]  age_step_reg;
  logic [7:0]  penalty_reg;

  branch_t     pending [$];
  lookup_t     lookups_due [$];
  logic [31:0] addr_pool [$];

  logic        in_fire = 1'b0;
  logic        calm = 1'b0;
  int          in_gap = 0;
  int          out_hold = 0;
  int          cycle_count = 0;
  int          error_count = 0;
  int          branches_sent = 0;
  int          evictions_seen = 0;
  branch_t     next_branch;
  lookup_t     predicted;
  lookup_t     head;

  set_assoc_btb_lru_counters_core #(
    .ENTRY_COUNT(ENTRIES),
    .WAY_COUNT  (WAYS),
    .AGE_BITS   (AGE_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_branch_address(in_branch_address),
    .in_branch_length (in_branch_length),
    .in_branch_type   (in_branch_type),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_set_index    (out_set_index),
    .out_way_index    (out_way_index),
    .out_evicted      (out_evicted),
    .out_stall_cycles (out_stall_cycles),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total)
  );

  always #5 clk = ~clk;

  // every entry ages, valid or not, saturating at the counter ceiling
  function automatic void age_entries(int unsigned amount);
    for (int i = 0; i < ENTRIES; i++) begin
      if (btb_age[i] + amount > AGE_CEIL) btb_age[i] = AGE_CEIL;
      else btb_age[i] = btb_age[i] + amount;
    end
  endfunction

  // lookup, replacement and counter update for one branch
  function automatic lookup_t btb_lookup(logic [31:0] addr, logic [3:0] len, logic [2:0] kind);
    lookup_t     r;
    int unsigned set;
    int unsigned base;
    int unsigned way;
    bit          found;
    r = '{default: '0};
    set = (addr >> 2) % SETS;
    base = set * WAYS;
    way = 0;
    found = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (!r.hit && btb_valid[base + w] && btb_tag[base + w] == addr) begin
        r.hit = 1'b1;
        way = w;
      end
    end
    if (r.hit) begin
      hit_count++;
      btb_age[base + way] = 0;
      age_entries(32'(age_step_reg));
    end else begin
      miss_count++;
      age_entries(32'(penalty_reg));
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !btb_valid[base + w]) begin
          way = w;
          found = 1'b1;
        end
      end
      // full set: oldest way, ties go to the higher way
      if (!found) begin
        way = 0;
        for (int w = 1; w < WAYS; w++)
          if (!(btb_age[base + way] > btb_age[base + w])) way = w;
        r.evicted = 1'b1;
      end
      btb_valid[base + way]  = 1'b1;
      btb_tag[base + way]    = addr;
      btb_target[base + way] = addr + 32'(len);
      btb_class[base + way]  = (kind >= BR_UNCOND && kind <= BR_SYSCALL);
      btb_age[base + way]    = 0;
      r.stall_cycles = penalty_reg;
    end
    r.set_index = set[7:0];
    r.way_index = way[1:0];
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic void queue_branch(logic [31:0] addr, logic [3:0] len, logic [2:0] kind);
    branch_t b;
    b.address = addr;
    b.length = len;
    b.kind = kind;
    pending.push_back(b);
  endfunction

  // mix of reuse (hits), crowded sets (evictions), aliases and fresh addresses
  function automatic void queue_random_branch();
    logic [31:0] r;
    logic [31:0] a;
    logic [7:0]  hot_set;
    int          pick;
    pick = $urandom_range(0, 99);
    r = $urandom();
    case ($urandom_range(0, 3))
      0: hot_set = 8'h00;
      1: hot_set = 8'h5a;
      2: hot_set = 8'h81;
      default: hot_set = 8'hff;
    endcase
    if (addr_pool.size() > 0 && pick < 45) begin
      a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    end else begin
      if (pick < 70) a = {r[31:10], hot_set, r[1:0]};
      else if (addr_pool.size() > 0 && pick < 85)
        a = addr_pool[$urandom_range(0, addr_pool.size() - 1)] ^ (32'h1 << $urandom_range(0, 31));
      else a = r;
      addr_pool.push_back(a);
      if (addr_pool.size() > POOL_DEPTH) void'(addr_pool.pop_front());
    end
    queue_branch(a, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
  endfunction

  task automatic wait_idle();
    int idle_run;
    idle_run = 0;
    while (idle_run < DRAIN_CYCLES) begin
      @(negedge clk);
      if (pending.size() == 0 && !in_valid && lookups_due.size() == 0) idle_run++;
      else idle_run = 0;
    end
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_HIT_AGE_STEP) age_step_reg = value;
    else penalty_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               lookups_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // input transfer: predict the result of the branch on the bus
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predicted = btb_lookup(in_branch_address, in_branch_length, in_branch_type);
      if (predicted.evicted) evictions_seen++;
      lookups_due.push_back(predicted);
      branches_sent++;
      in_fire <= 1'b1;
    end else begin
      in_fire <= 1'b0;
    end
  end

  // input driver with random idle bursts after a transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        next_branch = pending.pop_front();
        in_branch_address <= next_branch.address;
        in_branch_length <= next_branch.length;
        in_branch_type <= next_branch.kind;
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall bursts
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      out_stall <= 1'b1;
      out_hold = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result transfer: compare against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (lookups_due.size() == 0) begin
        report_mismatch("result with nothing pending, hit_total", out_hit_total, 32'd0);
      end else begin
        head = lookups_due.pop_front();
        if (out_hit !== head.hit) report_mismatch("hit", 32'(out_hit), 32'(head.hit));
        if (out_set_index !== head.set_index)
          report_mismatch("set_index", 32'(out_set_index), 32'(head.set_index));
        if (out_way_index !== head.way_index)
          report_mismatch("way_index", 32'(out_way_index), 32'(head.way_index));
        if (out_evicted !== head.evicted)
          report_mismatch("evicted", 32'(out_evicted), 32'(head.evicted));
        if (out_stall_cycles !== head.stall_cycles)
          report_mismatch("stall_cycles", 32'(out_stall_cycles), 32'(head.stall_cycles));
        if (out_hit_total !== head.hit_total)
          report_mismatch("hit_total", out_hit_total, head.hit_total);
        if (out_miss_total !== head.miss_total)
          report_mismatch("miss_total", out_miss_total, head.miss_total);
      end
    end
  end

  // reset, directed branches, then random phases under changing registers
  initial begin
    logic [7:0] step_plan [PHASES];
    logic [7:0] penalty_plan [PHASES];
    step_plan    = '{8'd0, 8'd255, 8'd0,   8'd255, 8'd0, 8'd1};
    penalty_plan = '{8'd0, 8'd255, 8'd255, 8'd0,   8'd0, 8'd8};
    step_plan[4] = 8'($urandom_range(0, 255));
    penalty_plan[4] = 8'($urandom_range(0, 255));
    for (int i = 0; i < ENTRIES; i++) begin
      btb_valid[i] = 1'b0;
      btb_tag[i] = '0;
      btb_target[i] = '0;
      btb_class[i] = 1'b0;
      btb_age[i] = 0;
    end
    hit_count = '0;
    miss_count = '0;
    age_step_reg = HIT_AGE_STEP_RST;
    penalty_reg = MISS_PENALTY_RST;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every type code, low-bit aliases, full sets, wrapping targets
    queue_branch(32'h0000_0000, 4'd0,  3'd0);
    queue_branch(32'h0000_0000, 4'd15, 3'd7);
    queue_branch(32'h0000_0001, 4'd1,  3'd1);
    queue_branch(32'h0000_0400, 4'd2,  3'd2);
    queue_branch(32'h0000_0800, 4'd3,  3'd3);
    queue_branch(32'h0000_0c00, 4'd4,  3'd4);
    queue_branch(32'h0000_0001, 4'd5,  3'd5);
    queue_branch(32'hffff_ffff, 4'd15, 3'd6);
    queue_branch(32'hffff_fffc, 4'd8,  3'd7);
    queue_branch(32'hffff_ffff, 4'd0,  3'd0);
    queue_branch(32'h8000_0000, 4'd1,  3'd1);
    queue_branch(32'h7fff_ffff, 4'd14, 3'd2);
    queue_branch(32'haaaa_aaaa, 4'd10, 3'd3);
    queue_branch(32'h5555_5555, 4'd5,  3'd4);
    queue_branch(32'haaaa_aaaa, 4'd0,  3'd5);
    queue_branch(32'h0000_1000, 4'd7,  3'd0);
    queue_branch(32'h0000_0000, 4'd9,  3'd1);
    queue_branch(32'h0000_03fc, 4'd15, 3'd3);
    queue_branch(32'h5555_5555, 4'd3,  3'd6);
    queue_branch(32'h0000_0400, 4'd12, 3'd7);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_HIT_AGE_STEP, step_plan[p]);
      write_reg(CFG_MISS_PENALTY, penalty_plan[p]);
      calm = (p == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) queue_random_branch();
    end
    wait_idle();

    $display("checked %0d branch lookups under %0d register settings", branches_sent,
             PHASES + 1);
    $display("predicted %0d hits, %0d misses, %0d evictions", hit_count, miss_count,
             evictions_seen);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sabtb_pkg.sv
src/sabtb_ram.sv
src/sabtb_ctrl.sv
src/sabtb_dp.sv
src/set_assoc_btb_lru_counters_core.sv
src/sabtb_chk.sv
dv/tb_set_assoc_btb_lru_counters_core.sv
